### sv/shs_pkg.sv
// ---------------------------------------------------------------------------
// shs_pkg: shared types and constants of the stamped hash set
// States of the sequencer, outcome codes, command codes and the constants of
// the splitmix64 finalizer.
// ---------------------------------------------------------------------------
package shs_pkg;

   // command codes of an input transfer
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // fixed width of the reported slot index
   localparam int SLOT_INDEX_W = 10;

   // splitmix64 finalizer constants
   localparam logic [63:0] MIX_ADD  = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MIX_MUL1 = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MIX_MUL2 = 64'h94d0_49bb_1331_11eb;
   localparam int MIX_SHIFT1 = 30;
   localparam int MIX_SHIFT2 = 27;
   localparam int MIX_SHIFT3 = 31;

   // result codes
   typedef enum logic [1:0] {
      OUT_INSERTED = 2'd0,
      OUT_PRESENT  = 2'd1,
      OUT_FULL     = 2'd2,
      OUT_CLEARED  = 2'd3
   } outcome_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_MIX1,
      ST_MUL_LL,
      ST_MUL_LH,
      ST_MUL_HL,
      ST_MIX2,
      ST_FINAL,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

### sv/shs_ram.sv
// ---------------------------------------------------------------------------
// shs_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module shs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/stamped_hash_set_insert_top.sv
// ---------------------------------------------------------------------------
// stamped_hash_set_insert_top: set of 64-bit keys with generation stamps
// Open-addressed table, splitmix64 home slot, linear probing, clear by
// advancing the generation.
// ---------------------------------------------------------------------------
// One item at a time. An insert item runs the splitmix64 finalizer through
// one shared 32x32 multiplier (three partial products per 64-bit multiply),
// then probes p slots in turn, where p is 1 to 2^LOG_SLOTS, on the registered
// read port of the key and stamp memories. It then hands the result to the
// output register once that is free and returns to idle. A clear item
// advances the generation, except when the generation wraps, where the stamp
// memory is zeroed one slot per cycle and the generation restarts at one.
// The same zeroing pass runs after reset before the first item is accepted.
// A finished result waits in the output register while the next item is
// already accepted.
module stamped_hash_set_insert_top
   import shs_pkg::*;
#(
   parameter int LOG_SLOTS  = 10,
   parameter int STAMP_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_command,
   input  logic [63:0]             req_key,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_outcome,
   output logic [SLOT_INDEX_W-1:0] rsp_slot_index
);

   localparam int SLOTS = 1 << LOG_SLOTS;

   // sequencer and datapath registers
   state_type               state_ff, state_in;
   logic [STAMP_BITS-1:0]   gen_ff, gen_in;
   logic [63:0]             v_ff, v_in;
   logic [63:0]             acc_ff, acc_in;
   logic                    round_ff, round_in;
   logic [63:0]             key_ff, key_in;
   logic [LOG_SLOTS-1:0]    slot_ff, slot_in;
   logic [LOG_SLOTS-1:0]    probe_ff, probe_in;
   logic [LOG_SLOTS-1:0]    sweep_ff, sweep_in;
   logic                    clear_rsp_ff, clear_rsp_in;
   outcome_type             res_outcome_ff, res_outcome_in;
   logic [LOG_SLOTS-1:0]    res_slot_ff, res_slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   outcome_type             rsp_outcome_ff, rsp_outcome_in;
   logic [SLOT_INDEX_W-1:0] rsp_slot_ff, rsp_slot_in;

   // shared multiplier and memory ports
   logic [31:0]             mul_a, mul_b;
   logic [63:0]             mul_p;
   logic [63:0]             mul_const;
   logic [63:0]             fin;
   logic [STAMP_BITS-1:0]   gen_inc;
   logic                    stamp_we;
   logic [LOG_SLOTS-1:0]    stamp_waddr;
   logic [STAMP_BITS-1:0]   stamp_wdata;
   logic                    key_we;
   logic [STAMP_BITS-1:0]   stamp_rdata;
   logic [63:0]             key_rdata;

   assign mul_const = round_ff ? MIX_MUL2 : MIX_MUL1;
   assign mul_p     = mul_a * mul_b;
   assign fin       = v_ff ^ (v_ff >> MIX_SHIFT3);
   assign gen_inc   = gen_ff + 1'b1;

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = v_ff[31:0];
      mul_b = mul_const[31:0];
      unique case (state_ff)
         ST_MUL_LH: mul_b = mul_const[63:32];
         ST_MUL_HL: mul_a = v_ff[63:32];
         default: begin
            mul_a = v_ff[31:0];
            mul_b = mul_const[31:0];
         end
      endcase
   end

   // next state and datapath control
   always_comb begin
      state_in       = state_ff;
      gen_in         = gen_ff;
      v_in           = v_ff;
      acc_in         = acc_ff;
      round_in       = round_ff;
      key_in         = key_ff;
      slot_in        = slot_ff;
      probe_in       = probe_ff;
      sweep_in       = sweep_ff;
      clear_rsp_in   = clear_rsp_ff;
      res_outcome_in = res_outcome_ff;
      res_slot_in    = res_slot_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      stamp_we       = 1'b0;
      stamp_waddr    = slot_ff;
      stamp_wdata    = gen_ff;
      key_we         = 1'b0;
      req_stall      = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_command == CMD_CLEAR) begin
                  if (gen_inc == '0) begin
                     // generation wrapped: zero all stamps, restart at one
                     gen_in       = STAMP_BITS'(1);
                     sweep_in     = '0;
                     clear_rsp_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end else begin
                     gen_in         = gen_inc;
                     res_outcome_in = OUT_CLEARED;
                     res_slot_in    = '0;
                     state_in       = ST_DONE;
                  end
               end else begin
                  key_in   = req_key;
                  v_in     = req_key + MIX_ADD;
                  state_in = ST_MIX1;
               end
            end
         end
         ST_SWEEP: begin
            stamp_we    = 1'b1;
            stamp_waddr = sweep_ff;
            stamp_wdata = '0;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               if (clear_rsp_ff) begin
                  res_outcome_in = OUT_CLEARED;
                  res_slot_in    = '0;
                  state_in       = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
               clear_rsp_in = 1'b0;
            end
         end
         ST_MIX1: begin
            v_in     = v_ff ^ (v_ff >> MIX_SHIFT1);
            round_in = 1'b0;
            state_in = ST_MUL_LL;
         end
         ST_MUL_LL: begin
            acc_in   = mul_p;
            state_in = ST_MUL_LH;
         end
         ST_MUL_LH: begin
            acc_in   = {acc_ff[63:32] + mul_p[31:0], acc_ff[31:0]};
            state_in = ST_MUL_HL;
         end
         ST_MUL_HL: begin
            v_in     = {acc_ff[63:32] + mul_p[31:0], acc_ff[31:0]};
            state_in = round_ff ? ST_FINAL : ST_MIX2;
         end
         ST_MIX2: begin
            v_in     = v_ff ^ (v_ff >> MIX_SHIFT2);
            round_in = 1'b1;
            state_in = ST_MUL_LL;
         end
         ST_FINAL: begin
            // home slot; its read is issued now
            slot_in  = fin[LOG_SLOTS-1:0];
            probe_in = '0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // probe one slot per cycle
            if (stamp_rdata != gen_ff) begin
               stamp_we       = 1'b1;
               key_we         = 1'b1;
               res_outcome_in = OUT_INSERTED;
               res_slot_in    = slot_ff;
               state_in       = ST_DONE;
            end else if (key_rdata == key_ff) begin
               res_outcome_in = OUT_PRESENT;
               res_slot_in    = slot_ff;
               state_in       = ST_DONE;
            end else if (probe_ff == '1) begin
               res_outcome_in = OUT_FULL;
               res_slot_in    = '0;
               state_in       = ST_DONE;
            end else begin
               slot_in  = slot_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = res_outcome_ff;
               rsp_slot_in    = SLOT_INDEX_W'(res_slot_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         gen_ff       <= STAMP_BITS'(1);
         sweep_ff     <= '0;
         clear_rsp_ff <= 1'b0;
         probe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         sweep_ff     <= sweep_in;
         clear_rsp_ff <= clear_rsp_in;
         probe_ff     <= probe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      v_ff           <= v_in;
      acc_ff         <= acc_in;
      round_ff       <= round_in;
      key_ff         <= key_in;
      slot_ff        <= slot_in;
      res_outcome_ff <= res_outcome_in;
      res_slot_ff    <= res_slot_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   // stamp memory
   shs_ram #(
      .WIDTH (STAMP_BITS),
      .DEPTH (SLOTS)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_we),
      .wr_addr (stamp_waddr),
      .wr_data (stamp_wdata),
      .rd_addr (slot_in),
      .rd_data (stamp_rdata)
   );

   // key memory
   shs_ram #(
      .WIDTH (64),
      .DEPTH (SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (slot_ff),
      .wr_data (key_ff),
      .rd_addr (slot_in),
      .rd_data (key_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_outcome    = rsp_outcome_ff;
   assign rsp_slot_index = rsp_slot_ff;

`ifndef NO_ASSERTIONS
   // generation is never zero, so zeroed stamps are never live
   a_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      gen_ff != '0)
      else $error("generation reached zero");

   // a key is written only together with a live stamp
   a_key_with_stamp: assert property (@(posedge clock) disable iff (reset)
      key_we |-> (stamp_we && stamp_wdata == gen_ff && stamp_waddr == slot_ff))
      else $error("key written without matching stamp");

   // a probe sequence starts at its first slot
   a_probe_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL |=> (state_ff == ST_CHECK && probe_ff == '0))
      else $error("probe did not start at zero");

   // a new response comes only from the result hand-off
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside hand-off");

   // nonzero stamps are written only on insert
   a_stamp_source: assert property (@(posedge clock) disable iff (reset)
      (stamp_we && stamp_wdata != '0) |-> state_ff == ST_CHECK)
      else $error("stamp written outside probe");
`endif

endmodule
